// File: design/lenient_utf8_to_code_point_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lenient UTF-8 decoder
// Shorthand for clocked assertions that sit idle while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef LENIENT_UTF8_TO_CODE_POINT_TOP_MACROS_SVH
`define LENIENT_UTF8_TO_CODE_POINT_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define LU8_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define LU8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lu8_pkg.sv
// ----------------------------------------------------------------------------
// lu8_pkg
// Types, constants and decode helpers shared by the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lu8_pkg;

    typedef logic [7:0]  octet_t;
    typedef logic [20:0] cp_t;

    // Word on the byte side
    typedef struct packed {
        octet_t in_byte;
        logic   is_final;
    } byte_word_t;

    // Word on the code point side
    typedef struct packed {
        cp_t  code_point;
        logic last_of_string;
    } cp_word_t;

    // Run of bytes handed from front to back; only seq[0..len-1] are meaningful
    typedef struct packed {
        logic [3:0][7:0] seq;
        logic [2:0]      len;
        logic            fin;
    } job_t;

    localparam cp_t    QMARK      = 21'd63;
    localparam octet_t ASCII_TOP  = 8'h80;
    localparam int     Q_DEPTH    = 2;
    localparam int     QPTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int     QCNT_W     = $clog2(Q_DEPTH + 1);

    // Continuation bytes asked for by a lead; zero for ASCII or a bad lead
    function automatic logic [1:0] lead_class(input octet_t c);
        logic [1:0] k;
        k = 2'd0;
        if ((c & 8'hE0) == 8'hC0)
            k = 2'd1;
        else if ((c & 8'hF0) == 8'hE0)
            k = 2'd2;
        else if ((c & 8'hF8) == 8'hF0)
            k = 2'd3;
        return k;
    endfunction

    // Merge a lead with k continuation bytes, low six bits of each
    function automatic cp_t combine(input octet_t lead, input octet_t t1,
                                    input octet_t t2, input octet_t t3,
                                    input logic [1:0] k);
        cp_t v;
        case (k)
            2'd1:    v = {10'd0, lead[4:0], t1[5:0]};
            2'd2:    v = {5'd0, lead[3:0], t1[5:0], t2[5:0]};
            2'd3:    v = {lead[2:0], t1[5:0], t2[5:0], t3[5:0]};
            default: v = {13'd0, lead};
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/lu8_front.sv
// ----------------------------------------------------------------------------
// lu8_front
// Takes bytes, tracks the pending sequence and hands finished runs of bytes
// to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lu8_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire lu8_pkg::byte_word_t byte_word,
    input  wire logic               q_full,
    output logic                    push,
    output lu8_pkg::job_t           push_job
);
    import lu8_pkg::*;

    octet_t     lead_reg,  lead_next;
    logic [1:0] need_reg,  need_next;
    logic [1:0] tcnt_reg,  tcnt_next;
    octet_t     tail0_reg, tail1_reg;

    logic       accept;
    logic       pending;
    logic       complete;
    logic [1:0] cls;
    octet_t     b;

    assign b          = byte_word.in_byte;
    assign byte_stall = q_full;
    assign accept     = byte_valid && !q_full;
    assign pending    = (need_reg != 2'd0);
    assign cls        = lead_class(b);
    assign complete   = pending && ((({1'b0, tcnt_reg} + 3'd1) >= {1'b0, need_reg})
                                    || (tcnt_reg >= 2'd2));

    // Run of bytes as seen from this byte: held lead and tails, then the new byte
    always_comb
    begin
        push_job.seq[0] = pending ? lead_reg : b;
        push_job.seq[1] = (tcnt_reg == 2'd0) ? b : tail0_reg;
        push_job.seq[2] = (tcnt_reg == 2'd1) ? b : tail1_reg;
        push_job.seq[3] = b;
        push_job.len    = pending ? ({1'b0, tcnt_reg} + 3'd2) : 3'd1;
        push_job.fin    = byte_word.is_final;
    end

    // Sequence tracking
    always_comb
    begin
        lead_next = lead_reg;
        need_next = need_reg;
        tcnt_next = tcnt_reg;
        push      = 1'b0;
        if (accept)
        begin
            if (byte_word.is_final || complete)
            begin
                push      = 1'b1;
                lead_next = 8'd0;
                need_next = 2'd0;
                tcnt_next = 2'd0;
            end
            else if (!pending)
            begin
                if (b < ASCII_TOP || cls == 2'd0)
                begin
                    push = 1'b1;
                end
                else
                begin
                    lead_next = b;
                    need_next = cls;
                    tcnt_next = 2'd0;
                end
            end
            else
            begin
                tcnt_next = tcnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 8'd0;
            need_reg <= 2'd0;
            tcnt_reg <= 2'd0;
        end
        else
        begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            tcnt_reg <= tcnt_next;
        end
    end

    // Continuation bytes held while the sequence is open
    always_ff @(posedge clk)
    begin
        if (accept && pending && !byte_word.is_final && !complete)
        begin
            if (tcnt_reg[0])
                tail1_reg <= b;
            else
                tail0_reg <= b;
        end
    end

endmodule

`default_nettype wire

// File: design/lu8_queue.sv
// ----------------------------------------------------------------------------
// lu8_queue
// Short first-in first-out store of byte runs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lu8_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lu8_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output lu8_pkg::job_t      head_job
);
    import lu8_pkg::*;

    job_t               store [Q_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, wptr_next;
    logic [QPTR_W-1:0]  rptr_reg, rptr_next;
    logic [QCNT_W-1:0]  cnt_reg,  cnt_next;
    logic               do_pop;

    assign full       = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = store[rptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill count
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
            wptr_next = (wptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        if (do_pop)
            rptr_next = (rptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        if (push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store[wptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

// File: design/lu8_back.sv
// ----------------------------------------------------------------------------
// lu8_back
// Walks a byte run to the output register, one code point per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lu8_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire lu8_pkg::job_t head_job,
    output logic               pop,
    output logic               cp_valid,
    input  wire logic          cp_stall,
    output lu8_pkg::cp_word_t  cp_word
);
    import lu8_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic       cp_valid_reg, cp_valid_next;
    cp_word_t   cp_word_reg;

    octet_t     c;
    logic [1:0] k;
    logic [2:0] adv;
    logic [2:0] pos_after;
    logic       run_done;
    logic       out_free;
    logic       step;
    cp_t        cp_val;

    assign out_free = !cp_valid_reg || !cp_stall;
    assign step     = head_valid && out_free;
    assign c        = head_job.seq[pos_reg];
    assign k        = lead_class(c);

    // One decode step at the current position
    always_comb
    begin
        if (c < ASCII_TOP)
        begin
            cp_val = {13'd0, c};
            adv    = 3'd1;
        end
        else if (k != 2'd0 && ({1'b0, pos_reg} + {1'b0, k}) < head_job.len)
        begin
            cp_val = combine(c, head_job.seq[pos_reg + 2'd1],
                             head_job.seq[pos_reg + 2'd2],
                             head_job.seq[pos_reg + 2'd3], k);
            adv    = {1'b0, k} + 3'd1;
        end
        else
        begin
            cp_val = QMARK;
            adv    = 3'd1;
        end
    end

    assign pos_after = {1'b0, pos_reg} + adv;
    assign run_done  = (pos_after >= head_job.len);
    assign pop       = step && run_done;

    // Position and output valid
    always_comb
    begin
        pos_next      = pos_reg;
        cp_valid_next = cp_valid_reg;
        if (!cp_stall)
            cp_valid_next = 1'b0;
        if (step)
        begin
            cp_valid_next = 1'b1;
            pos_next      = run_done ? 2'd0 : pos_after[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 2'd0;
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            cp_valid_reg <= cp_valid_next;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cp_word_reg.code_point     <= cp_val;
            cp_word_reg.last_of_string <= head_job.fin && run_done;
        end
    end

    assign cp_valid = cp_valid_reg;
    assign cp_word  = cp_word_reg;

endmodule

`default_nettype wire

// File: design/lenient_utf8_to_code_point_top.sv
// ----------------------------------------------------------------------------
// lenient_utf8_to_code_point_top
// Lenient UTF-8 decoder: bytes in, code points out, bad leads give '?'.
//
//   channel   | direction | word        | handshake
//   byte      | in        | byte_word_t | byte_valid / byte_stall
//   cp        | out       | cp_word_t   | cp_valid / cp_stall
//
// One byte a cycle is taken unless stalled; a result passes the queue,
// then the output register. A final byte may give up to three results,
// one per unstalled cycle, set by the single decode step of the back end.
// Reset clears the pending sequence, the queue and the output valid.
// byte_stall rises only while the two-entry queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module lenient_utf8_to_code_point_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire lu8_pkg::byte_word_t byte_word,
    output logic                     cp_valid,
    input  wire logic                cp_stall,
    output lu8_pkg::cp_word_t        cp_word
);
    import lu8_pkg::*;

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    // Front: sequence tracking
    lu8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Queue between the two halves
    lu8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // Back: decode and output register
    lu8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .cp_word    (cp_word)
    );

endmodule

`default_nettype wire

// File: design/lu8_checker.sv
// ----------------------------------------------------------------------------
// lu8_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lenient_utf8_to_code_point_top_macros.svh"

module lu8_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                byte_valid,
    input wire logic                byte_stall,
    input wire lu8_pkg::byte_word_t byte_word,
    input wire logic                cp_valid,
    input wire logic                cp_stall,
    input wire lu8_pkg::cp_word_t   cp_word
);
    import lu8_pkg::*;

    logic [2:0] fin_open_reg, fin_open_next;
    logic       seen_reg;
    logic       fin_in;
    logic       last_out;

    assign fin_in   = byte_valid && !byte_stall && byte_word.is_final;
    assign last_out = cp_valid && !cp_stall && cp_word.last_of_string;

    // Strings taken in but not yet closed on the output side
    always_comb
    begin
        fin_open_next = fin_open_reg;
        if (fin_in && !last_out)
            fin_open_next = fin_open_reg + 3'd1;
        else if (!fin_in && last_out)
            fin_open_next = fin_open_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_open_reg <= 3'd0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            fin_open_reg <= fin_open_next;
            if (byte_valid && !byte_stall)
                seen_reg <= 1'b1;
        end
    end

    `LU8_ASSERT_NEXT(a_cp_hold, cp_valid && cp_stall, cp_valid && $stable(cp_word), "result word changed while stalled")
    `LU8_ASSERT_SAME(a_last_needs_final, last_out, fin_open_reg != 3'd0, "end of string without a final byte")
    `LU8_ASSERT_SAME(a_no_early_result, !seen_reg, !cp_valid, "result before any byte taken")

endmodule

bind lenient_utf8_to_code_point_top lu8_checker u_lu8_checker (.*);

`default_nettype wire

// File: test/lenient_utf8_to_code_point_top_tb.sv
// ----------------------------------------------------------------------------
// lenient_utf8_to_code_point_top_tb
// Drives byte strings into the lenient UTF-8 decoder and checks each code
// point word against a scoreboard that decodes the same bytes alongside.
// Directed strings cover the edge cases first. Random strings follow, mostly
// well-formed with random content, some truncated and some pure noise. Both
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module lenient_utf8_to_code_point_top_tb;

    import lu8_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 48;
    localparam int BYTE_TARGET = 405;
    localparam int CALM_AFTER = 350;
    localparam int HOLD_AT = 150;
    localparam int DRAIN_CYCLES = 8;

    // Decoder mirror: tracks the pending sequence and queues the code points due
    class cp_scoreboard;
        octet_t     lead_held;
        octet_t     tail_bytes [2];
        logic [1:0] tail_count;
        logic [1:0] bytes_needed;
        cp_word_t   cp_due [$];
        int         errors;

        function new();
            lead_held    = '0;
            tail_bytes   = '{8'h00, 8'h00};
            tail_count   = '0;
            bytes_needed = '0;
            errors       = 0;
        endfunction

        // Continuation bytes a lead asks for; 0 for ASCII or a bad lead
        function int tail_len(octet_t c);
            if (c[7:5] == 3'b110)
                return 1;
            if (c[7:4] == 4'b1110)
                return 2;
            if (c[7:3] == 5'b11110)
                return 3;
            return 0;
        endfunction

        // Lead at run[at] merged with the k bytes after it
        function cp_t merge_run(octet_t run [4], int at, int k);
            cp_t v;
            int  j;
            case (k)
                1:       v = cp_t'(run[at][4:0]);
                2:       v = cp_t'(run[at][3:0]);
                default: v = cp_t'(run[at][2:0]);
            endcase
            for (j = 1; j <= k; j++)
                v = (v << 6) | cp_t'(run[at + j][5:0]);
            return v;
        endfunction

        function void clear_pending();
            lead_held    = '0;
            tail_count   = '0;
            bytes_needed = '0;
        endfunction

        function void due(cp_t cp, logic last);
            cp_word_t w;
            w.code_point     = cp;
            w.last_of_string = last;
            cp_due = {cp_due, w};
        endfunction

        // Accepted byte word: work out the code points it releases
        function void note_byte(byte_word_t w);
            octet_t run [4];
            cp_t    got [3];
            int     n;
            int     i;
            int     j;
            int     k;
            int     made;
            n    = 0;
            i    = 0;
            made = 0;
            if (!w.is_final)
            begin
                if (bytes_needed == 0)
                begin
                    k = tail_len(w.in_byte);
                    if (w.in_byte < ASCII_TOP)
                        due(cp_t'(w.in_byte), 1'b0);
                    else if (k == 0)
                        due(QMARK, 1'b0);
                    else
                    begin
                        lead_held    = w.in_byte;
                        bytes_needed = k[1:0];
                        tail_count   = '0;
                    end
                end
                else if (int'(tail_count) + 1 >= int'(bytes_needed)
                         || tail_count >= 2)
                begin
                    run[0] = lead_held;
                    for (j = 0; j < int'(tail_count); j++)
                        run[1 + j] = tail_bytes[j];
                    run[1 + tail_count] = w.in_byte;
                    due(merge_run(run, 0, int'(bytes_needed)), 1'b0);
                    clear_pending();
                end
                else
                begin
                    tail_bytes[tail_count[0]] = w.in_byte;
                    tail_count = tail_count + 2'd1;
                end
                return;
            end

            // Final byte: flush everything held, re-reading leftovers as leads
            if (bytes_needed != 0)
            begin
                run[n] = lead_held;
                n = n + 1;
                for (j = 0; j < int'(tail_count); j++)
                begin
                    run[n] = tail_bytes[j];
                    n = n + 1;
                end
            end
            run[n] = w.in_byte;
            n = n + 1;
            clear_pending();
            while (i < n && made < 3)
            begin
                k = tail_len(run[i]);
                if (run[i] < ASCII_TOP)
                begin
                    got[made] = cp_t'(run[i]);
                    i = i + 1;
                end
                else if (k != 0 && i + k < n)
                begin
                    got[made] = merge_run(run, i, k);
                    i = i + k + 1;
                end
                else
                begin
                    got[made] = QMARK;
                    i = i + 1;
                end
                made = made + 1;
            end
            for (j = 0; j < made; j++)
                due(got[j], j == made - 1);
        endfunction

        // Accepted code point word against the oldest one due
        function void check_cp(cp_word_t w);
            cp_word_t e;
            if (cp_due.size() == 0)
            begin
                $error("code point word 0x%06h with none due", w.code_point);
                errors++;
                return;
            end
            e = cp_due.pop_front();
            if (w.code_point !== e.code_point)
            begin
                $error("code_point: expected 0x%06h, got 0x%06h",
                       e.code_point, w.code_point);
                errors++;
            end
            if (w.last_of_string !== e.last_of_string)
            begin
                $error("last_of_string: expected %0b, got %0b",
                       e.last_of_string, w.last_of_string);
                errors++;
            end
        endfunction

        function int pending();
            return cp_due.size();
        endfunction

        function bit clean();
            if (cp_due.size() != 0)
            begin
                $error("%0d code point words never arrived", cp_due.size());
                errors++;
            end
            return errors == 0;
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_word_t byte_word = '0;
    logic       cp_valid;
    logic       cp_stall = 1'b0;
    cp_word_t   cp_word;

    cp_scoreboard sb = new();
    int bytes_taken = 0;
    int bytes_sent = 0;
    int idle_cycles = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    lenient_utf8_to_code_point_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .cp_valid   (cp_valid),
        .cp_stall   (cp_stall),
        .cp_word    (cp_word)
    );

    always #1 clk = ~clk;

    // Handshake monitor and watchdog, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                sb.note_byte(byte_word);
                bytes_taken++;
            end
            if (cp_valid && !cp_stall)
                sb.check_cp(cp_word);
            if ((byte_valid && !byte_stall) || (cp_valid && !cp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                cp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                cp_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                cp_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                cp_stall <= 1'b0;
            end
        end
    end

    // One byte word, held until taken; may open with an idle burst
    task automatic send_byte(input octet_t b, input logic f);
        int start;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start = bytes_taken;
        byte_valid <= 1'b1;
        byte_word  <= '{in_byte: b, is_final: f};
        do
            @(negedge clk);
        while (bytes_taken == start);
        bytes_sent++;
    endtask

    task automatic send_str(input octet_t s [$]);
        foreach (s[i])
            send_byte(s[i], i == s.size() - 1);
    endtask

    // Mostly well-formed strings, sometimes cut short; else raw noise
    task automatic send_random_string();
        octet_t s [$];
        int     k;
        int     j;
        k = 0;
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 6))
                s = {s, octet_t'($urandom_range(0, 255))};
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                k = $urandom_range(0, 3);
                case (k)
                    0:       s = {s, octet_t'($urandom_range(0, 127))};
                    1:       s = {s, 8'hC0 | octet_t'($urandom_range(0, 31))};
                    2:       s = {s, 8'hE0 | octet_t'($urandom_range(0, 15))};
                    default: s = {s, 8'hF0 | octet_t'($urandom_range(0, 7))};
                endcase
                for (j = 0; j < k; j++)
                    s = {s, 8'h80 | octet_t'($urandom_range(0, 63))};
            end
            // truncate the last sequence now and then
            if (k != 0 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, k))
                    void'(s.pop_back());
        end
        send_str(s);
    endtask

    initial
    begin
        octet_t s [$];
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ASCII extremes, string end on plain ASCII
        s = {8'h00, 8'h7F};
        send_str(s);
        // bad leads
        s = {8'h80, 8'hF8, 8'hFF};
        send_str(s);
        // two, three and four byte forms, the last one at the top of the range
        s = {8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_str(s);
        // lone lead as final byte
        s = {8'hC3};
        send_str(s);
        // truncated four byte form: three words after the final byte
        s = {8'hF0, 8'h9F, 8'h98};
        send_str(s);
        // truncated lead followed by ASCII
        s = {8'hE2, 8'h41};
        send_str(s);
        // overlong and surrogate pass through
        s = {8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80};
        send_str(s);

        // random strings; long hold once, quiet towards the end
        while (bytes_sent < BYTE_TARGET)
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (bytes_sent >= CALM_AFTER)
                gaps_on = 1'b0;
            send_random_string();
        end
        byte_valid <= 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.clean())
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
